@@ rtl/sll_pkg.sv @@
`default_nettype none

package sll_pkg;

  // Node array size; two slots are taken by the free chain and list heads.
  localparam int NODE_SLOTS = 64;
  localparam int CELLS      = NODE_SLOTS - 2;

  // Fixed field widths of the item and result words.
  localparam int KIND_W   = 2;
  localparam int LEN_W    = 6;
  localparam int VAL_W    = 32;
  localparam int STATUS_W = 2;

  localparam logic [LEN_W-1:0] CELL_COUNT_LEN = LEN_W'(CELLS);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_INSERT   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRAVERSE = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD_POS  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd2;

  // Operations applied to every cell of the chain together.
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;
  localparam logic [1:0] OP_ROTATE = 2'd3;

  // Command broadcast along the chain.
  typedef struct packed {
    logic [1:0]       op;
    logic [LEN_W-1:0] pos;       // zero-based cell index of the splice
    logic [LEN_W-1:0] last_idx;  // index of the final occupied cell
  } cell_cmd_t;

endpackage

`default_nettype wire

@@ rtl/sll_cell.sv @@
`default_nettype none

module sll_cell (
  input  wire logic                     clk,
  input  wire sll_pkg::cell_cmd_t       cmd,
  input  wire logic [sll_pkg::LEN_W-1:0] idx,
  input  wire logic [sll_pkg::VAL_W-1:0] new_value,
  input  wire logic [sll_pkg::VAL_W-1:0] left_value,
  input  wire logic [sll_pkg::VAL_W-1:0] right_value,
  input  wire logic [sll_pkg::VAL_W-1:0] head_value,
  output logic      [sll_pkg::VAL_W-1:0] value_q
);

  logic [sll_pkg::VAL_W-1:0] value_r;
  logic [sll_pkg::VAL_W-1:0] value_nxt;

  // Each cell holds one list element; it takes a neighbour's word (or the new
  // word at the splice point) on a splice, an unlink or a rotation, and keeps its own otherwise.
  always_comb begin
    value_nxt = value_r;
    unique case (cmd.op)
      sll_pkg::OP_INSERT: begin
        if (idx > cmd.pos) begin
          value_nxt = left_value;
        end else if (idx == cmd.pos) begin
          value_nxt = new_value;
        end
      end
      sll_pkg::OP_DELETE: begin
        if (idx >= cmd.pos) begin
          value_nxt = right_value;
        end
      end
      sll_pkg::OP_ROTATE: begin
        if (idx == cmd.last_idx) begin
          value_nxt = head_value;
        end else begin
          value_nxt = right_value;
        end
      end
      default: begin
        value_nxt = value_r;
      end
    endcase
  end

  // Element storage needs no reset: cells beyond the length are never read.
  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_q = value_r;

endmodule

`default_nettype wire

@@ rtl/sll_chain.sv @@
`default_nettype none

module sll_chain (
  input  wire logic                      clk,
  input  wire sll_pkg::cell_cmd_t        cmd,
  input  wire logic [sll_pkg::VAL_W-1:0] new_value,
  output logic      [sll_pkg::VAL_W-1:0] head_value
);

  logic [sll_pkg::VAL_W-1:0] cell_val [sll_pkg::CELLS];

  // A row of cells in list order; cell 0 holds the first element and the
  // row wraps from the last cell back to cell 0 for rotation.
  for (genvar i = 0; i < sll_pkg::CELLS; i++) begin : g_cell
    logic [sll_pkg::VAL_W-1:0] left_w;
    logic [sll_pkg::VAL_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = new_value;
    end else begin : g_mid_l
      assign left_w = cell_val[i-1];
    end

    if (i == sll_pkg::CELLS - 1) begin : g_final
      assign right_w = cell_val[0];
    end else begin : g_mid_r
      assign right_w = cell_val[i+1];
    end

    sll_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .idx         (sll_pkg::LEN_W'(i)),
      .new_value   (new_value),
      .left_value  (left_w),
      .right_value (right_w),
      .head_value  (cell_val[0]),
      .value_q     (cell_val[i])
    );
  end

  assign head_value = cell_val[0];

endmodule

`default_nettype wire

@@ rtl/static_linked_list_engine_top.sv @@
`default_nettype none

// Ordered list engine with insert, delete and traverse commands.
// Input channel: a command word (in_kind, in_position, in_value) is taken
// at a rising edge where start is high and busy is low.
// Result channel: each result word sits on the out_ ports for exactly one
// cycle, marked by out_valid; out_last marks the final word of a command.
// The receiver cannot hold results off, and none is needed.
// Insert, delete, an unused kind and a traverse of an empty list give one
// word in the cycle after acceptance; busy stays low, so a new command can
// be taken in every cycle.
// A traverse of N elements gives N words, one for each element in list
// order, the last marked by out_last; busy is high while the elements are
// read out, so no new command is taken until then (a full list holds 62 elements).
// The words come from the row of element cells: the whole row rotates by
// one place per cycle, presenting the next element at cell 0.
// Reset (synchronous, active low) empties the list, drops busy and clears
// the result strobe; it takes effect at a rising clock edge while rst_n is low.

module static_linked_list_engine_top (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [sll_pkg::KIND_W-1:0]   in_kind,
  input  wire logic [sll_pkg::LEN_W-1:0]    in_position,
  input  wire logic signed [sll_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  output logic [sll_pkg::STATUS_W-1:0]      out_status,
  output logic [sll_pkg::LEN_W-1:0]         out_list_length,
  output logic signed [sll_pkg::VAL_W-1:0]  out_element,
  output logic                              out_element_valid,
  output logic                              out_last
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TRAV = 1'b1;

  localparam int LW = sll_pkg::LEN_W;

  logic                          state_r,   state_nxt;
  logic [LW-1:0]                 count_r,   count_nxt;
  logic [LW-1:0]                 remain_r,  remain_nxt;
  logic                          ovalid_r,  ovalid_nxt;
  logic [sll_pkg::STATUS_W-1:0]  ostatus_r, ostatus_nxt;
  logic [LW-1:0]                 olen_r,    olen_nxt;
  logic [sll_pkg::VAL_W-1:0]     oelem_r,   oelem_nxt;
  logic                          oev_r,     oev_nxt;
  logic                          olast_r,   olast_nxt;

  logic                          accept;
  logic [LW:0]                   count_p1;
  logic                          ins_bad;
  logic                          del_bad;
  logic                          full;
  sll_pkg::cell_cmd_t            cmd;
  logic [sll_pkg::VAL_W-1:0]     head_value;

  assign busy   = (state_r == ST_TRAV);
  assign accept = start && !busy;

  // Range and capacity checks on the incoming command word.
  assign count_p1 = {1'b0, count_r} + {{LW{1'b0}}, 1'b1};
  assign ins_bad  = (in_position == '0) || ({1'b0, in_position} > count_p1);
  assign del_bad  = (in_position == '0) || (in_position > count_r);
  assign full     = (count_r == sll_pkg::CELL_COUNT_LEN);

  // Command sequencing and the result word.
  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    remain_nxt   = remain_r;
    ovalid_nxt   = 1'b0;
    ostatus_nxt  = sll_pkg::STATUS_OK;
    olen_nxt     = count_r;
    oelem_nxt    = '0;
    oev_nxt      = 1'b0;
    olast_nxt    = 1'b1;
    cmd.op       = sll_pkg::OP_HOLD;
    cmd.pos      = in_position - {{(LW-1){1'b0}}, 1'b1};
    cmd.last_idx = count_r - {{(LW-1){1'b0}}, 1'b1};

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovalid_nxt = 1'b1;
          case (in_kind)
            sll_pkg::KIND_INSERT: begin
              if (ins_bad) begin
                ostatus_nxt = sll_pkg::STATUS_BAD_POS;
              end else if (full) begin
                ostatus_nxt = sll_pkg::STATUS_NO_FREE;
              end else begin
                cmd.op    = sll_pkg::OP_INSERT;
                count_nxt = count_p1[LW-1:0];
                olen_nxt  = count_p1[LW-1:0];
              end
            end
            sll_pkg::KIND_DELETE: begin
              if (del_bad) begin
                ostatus_nxt = sll_pkg::STATUS_BAD_POS;
              end else begin
                cmd.op    = sll_pkg::OP_DELETE;
                count_nxt = count_r - {{(LW-1){1'b0}}, 1'b1};
                olen_nxt  = count_nxt;
              end
            end
            sll_pkg::KIND_TRAVERSE: begin
              if (count_r != '0) begin
                ovalid_nxt = 1'b0;
                remain_nxt = count_r;
                state_nxt  = ST_TRAV;
              end
            end
            default: begin
              ostatus_nxt = sll_pkg::STATUS_OK;
            end
          endcase
        end
      end
      ST_TRAV: begin
        // Emit the element at cell 0 and rotate the row by one place.
        cmd.op     = sll_pkg::OP_ROTATE;
        ovalid_nxt = 1'b1;
        oelem_nxt  = head_value;
        oev_nxt    = 1'b1;
        olast_nxt  = (remain_r == {{(LW-1){1'b0}}, 1'b1});
        remain_nxt = remain_r - {{(LW-1){1'b0}}, 1'b1};
        if (olast_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  sll_chain u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .new_value  (in_value),
    .head_value (head_value)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      remain_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      remain_r <= remain_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    ostatus_r <= ostatus_nxt;
    olen_r    <= olen_nxt;
    oelem_r   <= oelem_nxt;
    oev_r     <= oev_nxt;
    olast_r   <= olast_nxt;
  end

  assign out_valid         = ovalid_r;
  assign out_status        = ostatus_r;
  assign out_list_length   = olen_r;
  assign out_element       = oelem_r;
  assign out_element_valid = oev_r;
  assign out_last          = olast_r;

  // The list never grows past the number of cells.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sll_pkg::CELL_COUNT_LEN)
    else $error("list length exceeds cell count");

  // Every traverse cycle produces a result word in the next cycle.
  a_trav_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TRAV |=> out_valid && out_element_valid)
    else $error("traverse cycle without element word");

  // An insert or delete gives a single final word, with no element, on the registered result port.
  a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_kind == sll_pkg::KIND_INSERT || in_kind == sll_pkg::KIND_DELETE)
    |=> out_valid && out_last && !out_element_valid)
    else $error("insert or delete word missing");

  // The final element word coincides with the engine having gone idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_element_valid && out_last |-> state_r == ST_IDLE)
    else $error("traverse ended without returning to idle");

endmodule

`default_nettype wire
